/* sv/cte_pkg.sv */
// Shared constants, types and helpers for the curve table evaluator.
// No dependencies; the top level imports everything from here.
package cte_pkg;

   localparam int MAX_POINTS  = 16;
   localparam int FRAC_BITS   = 16;
   localparam int STORE_DEPTH = 3 * MAX_POINTS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int IDX_W       = $clog2(MAX_POINTS);
   localparam int PC_W        = $clog2(MAX_POINTS + 1);
   localparam int T_W         = FRAC_BITS + 1;
   localparam int B_W         = T_W + 2;
   localparam int ACC_W       = 40;
   localparam int SAT_W       = 41;
   localparam int MUL_W       = 34;
   localparam int MAX_STEPS   = 32;
   localparam logic [T_W-1:0] ONE = T_W'(1) << FRAC_BITS;

   // configuration register indexes
   localparam logic [1:0] REG_TANGENT_MODE    = 2'd0;
   localparam logic [1:0] REG_POINT_COUNT     = 2'd1;
   localparam logic [1:0] REG_BISECTION_STEPS = 2'd2;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } entry_type;

   // clamp a wide signed value to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
      logic signed [31:0] r;
      if (v > SAT_W'(signed'(32'sh7fffffff))) begin
         r = 32'sh7fffffff;
      end else if (v < SAT_W'(signed'(32'sh80000000))) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* sv/curve_table_evaluator.sv */
// Curve table evaluator: point store, scan sequencer, shared multiplier and
// shared restoring divider. Depends on cte_pkg.
module curve_table_evaluator
   import cte_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_mode,
   input  logic [5:0]         req_slot_index,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_query_x,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_is_answer,
   output logic signed [31:0] rsp_value_y,
   output logic               rsp_fell_through,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [5:0]         csr_wdata
);
   // channel | direction | beat contents
   // req     | in        | mode, slot_index, coord_x, coord_y, query_x
   // rsp     | out       | is_answer, value_y, fell_through
   // csr     | in        | index, wdata (always ready)
   //
   // A linear query scans the segments, then runs the multiply and the long
   // divide. A Bezier query scans the same way, then divides for the target
   // parameter and, for each bisection step, runs the cubic on the shared
   // multiplier and a divide, plus a final cubic for the result.
   // Reset is synchronous and clears control state only; the store is not
   // cleared. req_ready drops while a query runs; one finished result waits
   // in the output register while the next beat can already be taken.

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_LP0   = 5'd1;
   localparam logic [4:0] S_LNX   = 5'd2;
   localparam logic [4:0] S_LMUL  = 5'd3;
   localparam logic [4:0] S_LDIV  = 5'd4;
   localparam logic [4:0] S_LFIN  = 5'd5;
   localparam logic [4:0] S_BP0   = 5'd6;
   localparam logic [4:0] S_BNX   = 5'd7;
   localparam logic [4:0] S_BT1   = 5'd8;
   localparam logic [4:0] S_BT2   = 5'd9;
   localparam logic [4:0] S_BREAL = 5'd10;
   localparam logic [4:0] S_BCUB  = 5'd11;
   localparam logic [4:0] S_BCMP  = 5'd12;
   localparam logic [4:0] S_DIV   = 5'd13;
   localparam logic [4:0] S_DONE  = 5'd14;

   localparam logic [3:0] C_LAST = 4'd11;

   // point store
   entry_type mem [STORE_DEPTH];
   entry_type rd_ff;
   logic [ADDR_W-1:0] rd_addr;

   // sequencer and datapath registers
   logic [4:0] state_ff, state_in, ret_ff, ret_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [T_W-1:0] xq_ff, xq_in;
   logic [PC_W-1:0] n_ff, n_in;
   logic [5:0] steps_ff, steps_in, k_ff, k_in;
   logic signed [31:0] px_ff, px_in, py_ff, py_in, nx_ff, nx_in, ny_ff, ny_in;
   logic signed [32:0] c1x_ff, c1x_in, c2x_ff, c2x_in, c1y_ff, c1y_in, c2y_ff, c2y_in;
   logic [31:0] den_ff, den_in, mag_ff, mag_in, dxq_ff, dxq_in;
   logic dyneg_ff, dyneg_in;
   logic [T_W-1:0] lower_ff, lower_in, upper_ff, upper_in, t_ff, t_in, realx_ff, realx_in;
   logic [T_W-1:0] s_ff, s_in, a_ff, a_in;
   logic [B_W-1:0] b0_ff, b0_in, b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [3:0] cstep_ff, cstep_in;
   logic ysel_ff, ysel_in;
   logic signed [2*MUL_W-1:0] prod_ff;
   logic signed [MUL_W-1:0] op_a, op_b;

   // divider registers
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dden_ff, dden_in;
   logic [63:0] dq_ff, dq_in;
   logic [5:0] dcnt_ff, dcnt_in;

   // result staging and output
   logic signed [31:0] res_y_ff, res_y_in;
   logic res_ans_ff, res_ans_in, res_fell_ff, res_fell_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_ans_ff, rsp_fell_ff;
   logic signed [31:0] rsp_y_ff;

   // configuration
   logic tmode_ff;
   logic [4:0] pcount_ff;
   logic [5:0] bsteps_ff;

   logic req_fire, out_load;
   logic [T_W-1:0] t1;
   logic [PC_W:0] i_next2;
   logic signed [33:0] xs;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign t1        = ONE - t_ff;
   assign xs        = {{(34-T_W){1'b0}}, xq_ff};
   assign i_next2   = (PC_W+1)'(i_ff) + (PC_W+1)'(2);
   assign out_load  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   // store write and registered read
   always_ff @(posedge clock) begin
      if (req_fire && !req_mode && (req_slot_index < 6'(STORE_DEPTH))) begin
         mem[ADDR_W'(req_slot_index)] <= '{x: req_coord_x, y: req_coord_y};
      end
      rd_ff <= mem[rd_addr];
   end

   // shared multiplier operand select
   always_comb begin
      op_a = '0;
      op_b = '0;
      if (state_ff == S_LMUL) begin
         op_a = MUL_W'(mag_ff);
         op_b = MUL_W'(dxq_ff);
      end else if (state_ff == S_BCUB) begin
         unique case (cstep_ff)
            4'd0: begin op_a = MUL_W'(t1);   op_b = MUL_W'(t1);   end
            4'd1: begin op_a = MUL_W'(t_ff); op_b = MUL_W'(t_ff); end
            4'd2: begin op_a = MUL_W'(s_ff); op_b = MUL_W'(t1);   end
            4'd3: begin op_a = MUL_W'(s_ff); op_b = MUL_W'(t_ff); end
            4'd4: begin op_a = MUL_W'(t1);   op_b = MUL_W'(a_ff); end
            4'd5: begin op_a = MUL_W'(a_ff); op_b = MUL_W'(t_ff); end
            4'd6: begin
               op_a = MUL_W'(b0_ff);
               op_b = ysel_ff ? MUL_W'(py_ff) : MUL_W'(px_ff);
            end
            4'd7: begin
               op_a = MUL_W'(b1_ff);
               op_b = ysel_ff ? MUL_W'(c1y_ff) : MUL_W'(c1x_ff);
            end
            4'd8: begin
               op_a = MUL_W'(b2_ff);
               op_b = ysel_ff ? MUL_W'(c2y_ff) : MUL_W'(c2x_ff);
            end
            4'd9: begin
               op_a = MUL_W'(b3_ff);
               op_b = ysel_ff ? MUL_W'(ny_ff) : MUL_W'(nx_ff);
            end
            default: begin op_a = '0; op_b = '0; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   // sequencer
   always_comb begin
      logic signed [33:0] dxs;
      logic signed [32:0] dys;
      logic signed [ACC_W:0] dcl;
      logic [31:0] dsel;
      logic [T_W:0] tsum;
      logic [32:0] r2;
      logic ge;
      logic [63:0] dvd;
      logic dlong, dstart;
      logic [T_W-1:0] qv, hi;

      state_in = state_ff;  ret_in = ret_ff;    i_in = i_ff;
      xq_in = xq_ff;        n_in = n_ff;        steps_in = steps_ff;  k_in = k_ff;
      px_in = px_ff;        py_in = py_ff;      nx_in = nx_ff;        ny_in = ny_ff;
      c1x_in = c1x_ff;      c2x_in = c2x_ff;    c1y_in = c1y_ff;      c2y_in = c2y_ff;
      den_in = den_ff;      mag_in = mag_ff;    dxq_in = dxq_ff;      dyneg_in = dyneg_ff;
      lower_in = lower_ff;  upper_in = upper_ff; t_in = t_ff;         realx_in = realx_ff;
      s_in = s_ff;          a_in = a_ff;
      b0_in = b0_ff;        b1_in = b1_ff;      b2_in = b2_ff;        b3_in = b3_ff;
      acc_in = acc_ff;      cstep_in = cstep_ff; ysel_in = ysel_ff;
      rem_in = rem_ff;      quo_in = quo_ff;    dden_in = dden_ff;    dq_in = dq_ff;
      dcnt_in = dcnt_ff;
      res_y_in = res_y_ff;  res_ans_in = res_ans_ff; res_fell_in = res_fell_ff;
      rd_addr = '0;
      dxs = '0;  dys = '0;  dcl = '0;  dsel = '0;  tsum = '0;
      r2 = '0;   ge = 1'b0; dvd = '0;  dlong = 1'b0; dstart = 1'b0;
      qv = '0;   hi = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (!req_mode) begin
                  res_y_in = '0;
                  res_ans_in = 1'b0;
                  res_fell_in = 1'b0;
                  state_in = S_DONE;
               end else begin
                  // clamp query to [0, ONE] and latch effective settings
                  if (req_query_x < 0) begin
                     xq_in = '0;
                  end else if (req_query_x > 32'(ONE)) begin
                     xq_in = ONE;
                  end else begin
                     xq_in = T_W'(req_query_x);
                  end
                  if (pcount_ff < 5'd2) begin
                     n_in = PC_W'(2);
                  end else if (32'(pcount_ff) > MAX_POINTS) begin
                     n_in = PC_W'(MAX_POINTS);
                  end else begin
                     n_in = PC_W'(pcount_ff);
                  end
                  steps_in = (bsteps_ff > 6'(MAX_STEPS)) ? 6'(MAX_STEPS) : bsteps_ff;
                  i_in = '0;
                  rd_addr = tmode_ff ? ADDR_W'(1) : ADDR_W'(0);
                  state_in = tmode_ff ? S_BP0 : S_LP0;
               end
            end
         end

         // linear scan
         S_LP0: begin
            px_in = rd_ff.x;
            py_in = rd_ff.y;
            rd_addr = ADDR_W'(1);
            state_in = S_LNX;
         end
         S_LNX: begin
            dxs = xs - 34'(px_ff);
            if (xs >= 34'(px_ff) && xs < 34'(rd_ff.x)) begin
               dys = 33'(rd_ff.y) - 33'(py_ff);
               dyneg_in = dys[32];
               mag_in = dys[32] ? 32'(-dys) : 32'(dys);
               dxq_in = dxs[31:0];
               den_in = 32'(34'(rd_ff.x) - 34'(px_ff));
               state_in = S_LMUL;
            end else if (i_next2 < (PC_W+1)'(n_ff)) begin
               px_in = rd_ff.x;
               py_in = rd_ff.y;
               i_in = i_ff + 1'b1;
               rd_addr = ADDR_W'(i_next2);
            end else begin
               res_y_in = rd_ff.y;
               res_ans_in = 1'b1;
               res_fell_in = 1'b1;
               state_in = S_DONE;
            end
         end
         S_LMUL: state_in = S_LDIV;
         S_LDIV: begin
            dvd = 64'(prod_ff);
            dlong = 1'b1;
            dstart = 1'b1;
            ret_in = S_LFIN;
         end
         S_LFIN: begin
            res_y_in = dyneg_ff ? sat32(SAT_W'(py_ff) - SAT_W'(quo_ff))
                                : sat32(SAT_W'(py_ff) + SAT_W'(quo_ff));
            res_ans_in = 1'b1;
            res_fell_in = 1'b0;
            state_in = S_DONE;
         end

         // Bezier scan
         S_BP0: begin
            px_in = rd_ff.x;
            py_in = rd_ff.y;
            rd_addr = ADDR_W'(4);
            state_in = S_BNX;
         end
         S_BNX: begin
            if (xs == 34'(px_ff)) begin
               res_y_in = py_ff;
               res_ans_in = 1'b1;
               res_fell_in = 1'b0;
               state_in = S_DONE;
            end else if (xs > 34'(px_ff) && xs < 34'(rd_ff.x)) begin
               nx_in = rd_ff.x;
               ny_in = rd_ff.y;
               den_in = 32'(34'(rd_ff.x) - 34'(px_ff));
               rd_addr = ADDR_W'(8'(i_ff) * 8'd3 + 8'd2);
               state_in = S_BT1;
            end else if (i_next2 < (PC_W+1)'(n_ff)) begin
               px_in = rd_ff.x;
               py_in = rd_ff.y;
               i_in = i_ff + 1'b1;
               rd_addr = ADDR_W'(8'(i_ff) * 8'd3 + 8'd7);
            end else begin
               res_y_in = rd_ff.y;
               res_ans_in = 1'b1;
               res_fell_in = 1'b1;
               state_in = S_DONE;
            end
         end
         S_BT1: begin
            c1x_in = 33'(px_ff) + 33'(rd_ff.x);
            c1y_in = 33'(py_ff) + 33'(rd_ff.y);
            rd_addr = ADDR_W'(8'(i_ff) * 8'd3 + 8'd3);
            state_in = S_BT2;
         end
         S_BT2: begin
            c2x_in = 33'(nx_ff) + 33'(rd_ff.x);
            c2y_in = 33'(ny_ff) + 33'(rd_ff.y);
            dxs = xs - 34'(px_ff);
            dvd = 64'(dxs[31:0]) << FRAC_BITS;
            dstart = 1'b1;
            ret_in = S_BREAL;
            lower_in = '0;
            upper_in = ONE;
            t_in = ONE >> 1;
            k_in = '0;
         end
         S_BREAL: begin
            realx_in = T_W'(quo_ff);
            ysel_in = (steps_ff == 6'd0);
            cstep_in = '0;
            state_in = S_BCUB;
         end

         // cubic on the shared multiplier, one product per cycle
         S_BCUB: begin
            hi = prod_ff[2*FRAC_BITS:FRAC_BITS];
            cstep_in = cstep_ff + 1'b1;
            unique case (cstep_ff)
               4'd1: s_in = hi;
               4'd2: a_in = hi;
               4'd3: b0_in = B_W'(hi);
               4'd4: b1_in = B_W'(hi) + (B_W'(hi) << 1);
               4'd5: b2_in = B_W'(hi) + (B_W'(hi) << 1);
               4'd6: b3_in = B_W'(hi);
               4'd7: acc_in = ACC_W'(prod_ff >>> FRAC_BITS);
               4'd8, 4'd9, 4'd10: acc_in = acc_ff + ACC_W'(prod_ff >>> FRAC_BITS);
               C_LAST: begin
                  if (ysel_ff) begin
                     res_y_in = sat32(SAT_W'(acc_ff));
                     res_ans_in = 1'b1;
                     res_fell_in = 1'b0;
                     state_in = S_DONE;
                  end else begin
                     // offset from the segment start, clamped to [0, den]
                     dcl = (ACC_W+1)'(acc_ff) - (ACC_W+1)'(px_ff);
                     if (dcl < 0) begin
                        dsel = '0;
                     end else if (dcl > (ACC_W+1)'(den_ff)) begin
                        dsel = den_ff;
                     end else begin
                        dsel = dcl[31:0];
                     end
                     dvd = 64'(dsel) << FRAC_BITS;
                     dstart = 1'b1;
                     ret_in = S_BCMP;
                  end
               end
               default: ;
            endcase
         end
         S_BCMP: begin
            qv = T_W'(quo_ff);
            if (qv > realx_ff) begin
               upper_in = t_ff;
               tsum = (T_W+1)'(t_ff) + (T_W+1)'(lower_ff);
            end else begin
               lower_in = t_ff;
               tsum = (T_W+1)'(t_ff) + (T_W+1)'(upper_ff);
            end
            t_in = tsum[T_W:1];
            k_in = k_ff + 1'b1;
            ysel_in = ((k_ff + 1'b1) == steps_ff);
            cstep_in = '0;
            state_in = S_BCUB;
         end

         // restoring divider, one quotient bit a cycle
         S_DIV: begin
            r2 = {rem_ff, dq_ff[63]};
            ge = (r2 >= {1'b0, dden_ff});
            rem_in = ge ? 32'(r2 - {1'b0, dden_ff}) : r2[31:0];
            quo_in = {quo_ff[30:0], ge};
            dq_in = dq_ff << 1;
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == 6'd1) begin
               state_in = ret_ff;
            end
         end

         S_DONE: begin
            if (out_load) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // divider start; the quotient is known to fit in the bits iterated
      if (dstart) begin
         dden_in = den_ff;
         quo_in = '0;
         if (dlong) begin
            rem_in = dvd[63:32];
            dq_in = {dvd[31:0], 32'd0};
            dcnt_in = 6'd32;
         end else begin
            rem_in = 32'(dvd >> T_W);
            dq_in = dvd << (64 - T_W);
            dcnt_in = 6'(T_W);
         end
         state_in = S_DIV;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         tmode_ff <= 1'b0;
         pcount_ff <= 5'd2;
         bsteps_ff <= 6'd16;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_TANGENT_MODE:    tmode_ff <= csr_wdata[0];
               REG_POINT_COUNT:     pcount_ff <= csr_wdata[4:0];
               REG_BISECTION_STEPS: bsteps_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ret_ff <= ret_in;       i_ff <= i_in;         xq_ff <= xq_in;
      n_ff <= n_in;           steps_ff <= steps_in; k_ff <= k_in;
      px_ff <= px_in;         py_ff <= py_in;       nx_ff <= nx_in;     ny_ff <= ny_in;
      c1x_ff <= c1x_in;       c2x_ff <= c2x_in;     c1y_ff <= c1y_in;   c2y_ff <= c2y_in;
      den_ff <= den_in;       mag_ff <= mag_in;     dxq_ff <= dxq_in;   dyneg_ff <= dyneg_in;
      lower_ff <= lower_in;   upper_ff <= upper_in; t_ff <= t_in;       realx_ff <= realx_in;
      s_ff <= s_in;           a_ff <= a_in;
      b0_ff <= b0_in;         b1_ff <= b1_in;       b2_ff <= b2_in;     b3_ff <= b3_in;
      acc_ff <= acc_in;       cstep_ff <= cstep_in; ysel_ff <= ysel_in;
      rem_ff <= rem_in;       quo_ff <= quo_in;     dden_ff <= dden_in; dq_ff <= dq_in;
      dcnt_ff <= dcnt_in;
      res_y_ff <= res_y_in;   res_ans_ff <= res_ans_in; res_fell_ff <= res_fell_in;
      if (out_load) begin
         rsp_y_ff <= res_y_ff;
         rsp_ans_ff <= res_ans_ff;
         rsp_fell_ff <= res_fell_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_answer    = rsp_ans_ff;
   assign rsp_value_y      = rsp_y_ff;
   assign rsp_fell_through = rsp_fell_ff;

   // checks
   a_ack_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_answer |-> rsp_value_y == 0 && !rsp_fell_through)
      else $error("write acknowledge carries a nonzero payload");

   a_t_bracketed: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_BCUB |-> lower_ff <= t_ff && t_ff <= upper_ff)
      else $error("bisection parameter left its bracket");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_ff < dden_ff)
      else $error("divider remainder not below divisor");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff != S_IDLE)
      else $error("accepted beat did not start work");

endmodule
